@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Check that a trigger is followed by a condition at the next edge.
`define ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

@@ design/ptgr_pkg.sv @@
// ----------------------------------------------------------------------------
// ptgr_pkg
// Types, constants and codes shared by the gray conversion and rotation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptgr_pkg;

   // Panel geometry
   localparam int PANEL_WIDTH  = 1024;
   localparam int PANEL_HEIGHT = 768;

   // Field widths
   localparam int DIM_W   = 11;         // source size and counters
   localparam int DIMX_W  = DIM_W + 1;  // room for count + 1 and panel sizes
   localparam int ADDR_W  = 20;
   localparam int WORD_W  = 32;
   localparam int GRAY_W  = 8;
   localparam int LSUM_W  = 16;         // 77+150+29 = 256, so 8 + 8 bits

   // Luma weights
   localparam logic [GRAY_W-1:0] LUMA_R = 8'd77;
   localparam logic [GRAY_W-1:0] LUMA_G = 8'd150;
   localparam logic [GRAY_W-1:0] LUMA_B = 8'd29;

   // Queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // CSR
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_FORMAT  = 2'd0,
      CSR_ROTATION      = 2'd1,
      CSR_SOURCE_WIDTH  = 2'd2,
      CSR_SOURCE_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      FMT_RGBA8888 = 3'd0,
      FMT_BGRA8888 = 3'd1,
      FMT_RGBX8888 = 3'd2,
      FMT_BGRX8888 = 3'd3,
      FMT_RGB888   = 3'd4,
      FMT_RGB565   = 3'd5,
      FMT_GRAY8    = 3'd6
   } format_type;

   typedef enum logic [2:0] {
      ROT_NONE      = 3'd0,
      ROT_180       = 3'd1,
      ROT_CCW90     = 3'd2,
      ROT_CW90      = 3'd3,
      ROT_TRANSPOSE = 3'd4
   } rotation_type;

   localparam logic [DIM_W-1:0] SOURCE_WIDTH_RESET  = 11'd1024;
   localparam logic [DIM_W-1:0] SOURCE_HEIGHT_RESET = 11'd768;

   typedef struct packed {
      format_type        pixel_format;
      rotation_type      rotation;
      logic [DIM_W-1:0]  source_width;
      logic [DIM_W-1:0]  source_height;
   } cfg_type;

   // One classified pixel on its way from front to back
   typedef struct packed {
      logic [GRAY_W-1:0] red;
      logic [GRAY_W-1:0] green;
      logic [GRAY_W-1:0] blue;
      logic [ADDR_W-1:0] dest_x;
      logic [ADDR_W-1:0] dest_y;
      logic              geometry_error;
      logic              frame_last;
   } entry_type;

   // Queue handshake toward either side
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

@@ design/ptgr_front.sv @@
// ----------------------------------------------------------------------------
// ptgr_front
// Accepts source pixels, decodes the format into channels, tracks the source
// position and works out the rotated panel coordinates and the flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptgr_front import ptgr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [WORD_W-1:0] req_pixel_word,
   input  fifo_status_type   fifo_status,
   output logic              push,
   output entry_type         push_entry
);

   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [DIMX_W-1:0] col_plus, row_plus;
   logic              last_col, last_row;
   logic [ADDR_W-1:0] sx, sy, w_ext, h_ext;
   logic              fmt_bad;
   logic [4:0]        r5, b5;
   logic [5:0]        g6;
   logic [GRAY_W-1:0] chan_red, chan_green, chan_blue;
   logic [ADDR_W-1:0] dest_x, dest_y;
   logic              geom_err;

   assign req_ready = !fifo_status.full;
   assign push      = req_valid && req_ready;

   assign col_plus = DIMX_W'(col_ff) + DIMX_W'(1);
   assign row_plus = DIMX_W'(row_ff) + DIMX_W'(1);
   assign last_col = col_plus >= DIMX_W'(cfg.source_width);
   assign last_row = row_plus >= DIMX_W'(cfg.source_height);

   assign sx    = ADDR_W'(col_ff);
   assign sy    = ADDR_W'(row_ff);
   assign w_ext = ADDR_W'(cfg.source_width);
   assign h_ext = ADDR_W'(cfg.source_height);

   assign r5 = req_pixel_word[15:11];
   assign g6 = req_pixel_word[10:5];
   assign b5 = req_pixel_word[4:0];

   // Channel decode; gray feeds one byte to all three channels (weights sum to 256)
   always_comb begin
      fmt_bad    = 1'b0;
      chan_red   = '0;
      chan_green = '0;
      chan_blue  = '0;
      case (cfg.pixel_format)
         FMT_RGBA8888, FMT_RGBX8888, FMT_RGB888: begin
            chan_red   = req_pixel_word[7:0];
            chan_green = req_pixel_word[15:8];
            chan_blue  = req_pixel_word[23:16];
         end
         FMT_BGRA8888, FMT_BGRX8888: begin
            chan_red   = req_pixel_word[23:16];
            chan_green = req_pixel_word[15:8];
            chan_blue  = req_pixel_word[7:0];
         end
         FMT_RGB565: begin
            chan_red   = {r5, r5[4:2]};
            chan_green = {g6, g6[5:4]};
            chan_blue  = {b5, b5[4:2]};
         end
         FMT_GRAY8: begin
            chan_red   = req_pixel_word[7:0];
            chan_green = req_pixel_word[7:0];
            chan_blue  = req_pixel_word[7:0];
         end
         default: begin
            fmt_bad = 1'b1;
         end
      endcase
   end

   // Geometry check and rotated coordinates, all modulo the address width
   always_comb begin
      dest_x   = '0;
      dest_y   = '0;
      geom_err = 1'b1;
      case (cfg.rotation)
         ROT_NONE: begin
            dest_x = sx;
            dest_y = sy;
         end
         ROT_180: begin
            dest_x = w_ext - ADDR_W'(1) - sx;
            dest_y = h_ext - ADDR_W'(1) - sy;
         end
         ROT_CCW90: begin
            dest_x = sy;
            dest_y = w_ext - ADDR_W'(1) - sx;
         end
         ROT_CW90: begin
            dest_x = h_ext - ADDR_W'(1) - sy;
            dest_y = sx;
         end
         ROT_TRANSPOSE: begin
            dest_x = sy;
            dest_y = sx;
         end
         default: begin
            dest_x = '0;
         end
      endcase
      if (cfg.rotation inside {ROT_NONE, ROT_180}) begin
         geom_err = fmt_bad
            || (DIMX_W'(cfg.source_width)  != DIMX_W'(PANEL_WIDTH))
            || (DIMX_W'(cfg.source_height) != DIMX_W'(PANEL_HEIGHT));
      end else if (cfg.rotation inside {[ROT_CCW90:ROT_TRANSPOSE]}) begin
         geom_err = fmt_bad
            || (DIMX_W'(cfg.source_width)  != DIMX_W'(PANEL_HEIGHT))
            || (DIMX_W'(cfg.source_height) != DIMX_W'(PANEL_WIDTH));
      end
   end

   assign push_entry = '{red: chan_red, green: chan_green, blue: chan_blue,
                         dest_x: dest_x, dest_y: dest_y, geometry_error: geom_err,
                         frame_last: last_col && last_row};

   // Source position counters, wrapping at row and frame end
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_plus[DIM_W-1:0];
         end else begin
            col_in = col_plus[DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   `ASSERT_NEXT(frame_end_wraps, push && push_entry.frame_last, col_ff == '0 && row_ff == '0, "counters did not wrap after frame end")
   `ASSERT_NEXT(row_end_clears_col, push && last_col, col_ff == '0, "column not cleared at row end")

endmodule

@@ design/ptgr_fifo.sv @@
// ----------------------------------------------------------------------------
// ptgr_fifo
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptgr_fifo import ptgr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  entry_type       push_entry,
   input  logic            pop,
   output entry_type       head_entry,
   output fifo_status_type status
);

   entry_type               slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;

   assign status.full  = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign status.empty = count_ff == '0;
   assign head_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_ALWAYS(fifo_count_bounded, count_ff <= FIFO_CNT_W'(FIFO_DEPTH), "queue count above depth")
   `ASSERT_ALWAYS(fifo_ptrs_match_count, wr_ptr_ff == rd_ptr_ff + FIFO_PTR_W'(count_ff), "queue pointers disagree with count")

endmodule

@@ design/ptgr_back.sv @@
// ----------------------------------------------------------------------------
// ptgr_back
// Computes luma and the panel address of the queue head and holds the result
// in the output register until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptgr_back import ptgr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  fifo_status_type   fifo_status,
   input  entry_type         head_entry,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [GRAY_W-1:0] rsp_gray_level,
   output logic [ADDR_W-1:0] rsp_dest_address,
   output logic              rsp_geometry_error,
   output logic              rsp_frame_last
);

   logic              valid_ff, valid_in;
   logic [GRAY_W-1:0] gray_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              err_ff;
   logic              last_ff;
   logic [LSUM_W-1:0] luma_sum;
   logic [ADDR_W-1:0] row_base;

   assign pop = !fifo_status.empty && (!valid_ff || rsp_ready);

   assign luma_sum = LSUM_W'(head_entry.red)   * LSUM_W'(LUMA_R)
                   + LSUM_W'(head_entry.green) * LSUM_W'(LUMA_G)
                   + LSUM_W'(head_entry.blue)  * LSUM_W'(LUMA_B);

   assign row_base = ADDR_W'(head_entry.dest_y * ADDR_W'(PANEL_WIDTH));
   assign addr_in  = head_entry.geometry_error ? '0 : row_base + head_entry.dest_x;

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         gray_ff <= luma_sum[LSUM_W-1:LSUM_W-GRAY_W];
         addr_ff <= addr_in;
         err_ff  <= head_entry.geometry_error;
         last_ff <= head_entry.frame_last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_gray_level     = gray_ff;
   assign rsp_dest_address   = addr_ff;
   assign rsp_geometry_error = err_ff;
   assign rsp_frame_last     = last_ff;

   `ASSERT_ALWAYS(discarded_addr_zero, !(valid_ff && err_ff) || addr_ff == '0, "discarded result carries an address")
   `ASSERT_NEXT(pop_loads_output, pop, valid_ff, "popped entry did not reach the output")

endmodule

@@ design/pixel_to_gray_rotate_unit.sv @@
// ----------------------------------------------------------------------------
// pixel_to_gray_rotate_unit
// Raster pixel stream to 8-bit gray with rotated panel addressing.
// ----------------------------------------------------------------------------
// Takes one source pixel per request in raster order, decodes it by the
// configured format, computes luma as (77R + 150G + 29B) >> 8 and gives the
// pixel's index in a 1024 x 768 panel buffer after the configured rotation.
// Sustained rate is one request per clock cycle while rsp_ready stays high;
// an accepted request is registered first in the front-to-back queue and then
// in the output register. The four-entry queue sets how far the front runs
// ahead of a stalled output: req_ready drops only when it is full.
// geometry_error flags a source size that does not match the panel after
// rotation, or an unknown format or rotation; such results carry address 0.
// frame_last marks the last pixel of a frame, after which the position
// counters wrap. Write CSRs only while no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_to_gray_rotate_unit import ptgr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   // source pixels
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WORD_W-1:0]     req_pixel_word,
   // results
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [GRAY_W-1:0]     rsp_gray_level,
   output logic [ADDR_W-1:0]     rsp_dest_address,
   output logic                  rsp_geometry_error,
   output logic                  rsp_frame_last
);

   // Configuration registers
   format_type       pixel_format_ff, pixel_format_in;
   rotation_type     rotation_ff, rotation_in;
   logic [DIM_W-1:0] source_width_ff, source_width_in;
   logic [DIM_W-1:0] source_height_ff, source_height_in;
   cfg_type          cfg;

   fifo_status_type  fifo_status;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head_entry;

   // Decode CSR writes; hold every register not addressed
   always_comb begin
      pixel_format_in  = pixel_format_ff;
      rotation_in      = rotation_ff;
      source_width_in  = source_width_ff;
      source_height_in = source_height_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PIXEL_FORMAT:  pixel_format_in  = format_type'(csr_write_data[2:0]);
            CSR_ROTATION:      rotation_in      = rotation_type'(csr_write_data[2:0]);
            CSR_SOURCE_WIDTH:  source_width_in  = csr_write_data;
            CSR_SOURCE_HEIGHT: source_height_in = csr_write_data;
            default: begin
               pixel_format_in = pixel_format_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff  <= FMT_RGBA8888;
         rotation_ff      <= ROT_NONE;
         source_width_ff  <= SOURCE_WIDTH_RESET;
         source_height_ff <= SOURCE_HEIGHT_RESET;
      end else begin
         pixel_format_ff  <= pixel_format_in;
         rotation_ff      <= rotation_in;
         source_width_ff  <= source_width_in;
         source_height_ff <= source_height_in;
      end
   end

   assign cfg.pixel_format  = pixel_format_ff;
   assign cfg.rotation      = rotation_ff;
   assign cfg.source_width  = source_width_ff;
   assign cfg.source_height = source_height_ff;

   // Front: accept, decode, position and classify
   ptgr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_word (req_pixel_word),
      .fifo_status    (fifo_status),
      .push           (push),
      .push_entry     (push_entry)
   );

   // Queue decoupling front and back
   ptgr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (fifo_status)
   );

   // Back: luma, address and output register
   ptgr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .fifo_status        (fifo_status),
      .head_entry         (head_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_gray_level     (rsp_gray_level),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_geometry_error (rsp_geometry_error),
      .rsp_frame_last     (rsp_frame_last)
   );

endmodule
